>>> rtl/gpps_pkg.sv
// Shared types, constants and tables for the GBM price path step block.
package gpps_pkg;

    localparam int PRICE_W       = 40;
    localparam int SAMPLE_W      = 16;
    localparam int IDX_W         = 16;
    localparam int LOG_W         = 40;
    localparam int DRIFT_W       = 22;
    localparam int VOL_W         = 19;
    localparam int TIME_W        = 23;
    localparam int STEPS_W       = 16;
    localparam int DT_W          = 39;
    localparam int DIFF_W        = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 40;
    localparam int Q_DEPTH       = 2;
    localparam int TAYLOR_TERMS  = 13;

    localparam int DEF_PRICE_FRAC_BITS  = 16;
    localparam int DEF_SAMPLE_FRAC_BITS = 12;

    // ln2 and log2(e) in fixed point
    localparam logic [32:0] LN2_Q32   = 33'd2977044472;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    // exp argument limit, 32.0 with 24 fraction bits
    localparam logic signed [LOG_W-1:0] EXP_LIM = 40'sd536870912;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIFT_RATE    = 3'd0,
        CFG_VOLATILITY    = 3'd1,
        CFG_INITIAL_PRICE = 3'd2,
        CFG_START_TIME    = 3'd3,
        CFG_END_TIME      = 3'd4,
        CFG_STEP_COUNT    = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic signed [DRIFT_W-1:0] drift_rate;
        logic [VOL_W-1:0]          volatility;
        logic [PRICE_W-1:0]        initial_price;
        logic [TIME_W-1:0]         start_time;
        logic [TIME_W-1:0]         end_time;
        logic [STEPS_W-1:0]        step_count;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       start;
        logic [IDX_W-1:0]           idx;
        logic                       last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_DRIFT_M,
        S_DRIFT_A,
        S_DRIFT_SUM,
        S_SQRT,
        S_DIFF,
        S_LN_NORM,
        S_LN_SQ,
        S_LN_MUL,
        S_STEP_MUL,
        S_STEP_SUM,
        S_EXP_MUL,
        S_EXP_Z,
        S_TAY_A,
        S_TAY_B,
        S_TAY_C,
        S_EXP_SHIFT,
        S_OUT
    } t_back_state;

    // floor((2^32-1)/k); the quotient estimate is then at most one low
    function automatic logic [31:0] f_recip(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd2:    r = 32'd2147483647;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741823;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870911;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            4'd13:   r = 32'd330382099;
            default: r = 32'd4294967295;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/gpps_front.sv
// Front end: accepts sample words, tracks the step within the path, tags each word.
module gpps_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [gpps_pkg::SAMPLE_W-1:0]    i_normal_sample,
    input  logic [gpps_pkg::STEPS_W-1:0]            i_step_count,
    input  gpps_pkg::t_q_status                     i_q_status,
    output gpps_pkg::t_push                         o_push
);
    import gpps_pkg::*;

    logic [IDX_W-1:0] r_counter;
    logic [IDX_W-1:0] n_counter;
    logic             w_last;
    logic             w_take;

    // a step count of zero behaves as one: counter+1 >= 0 always holds
    assign w_last  = ({1'b0, r_counter} + 17'd1) >= {1'b0, i_step_count};
    assign o_ready = !i_q_status.full;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        o_push.valid       = w_take;
        o_push.item.sample = i_normal_sample;
        o_push.item.start  = (r_counter == '0);
        o_push.item.idx    = r_counter;
        o_push.item.last   = w_last;
        n_counter = r_counter;
        if (w_take) begin
            n_counter = w_last ? '0 : r_counter + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else begin
            r_counter <= n_counter;
        end
    end

endmodule

>>> rtl/gpps_queue.sv
// Short queue of tagged sample words between front and back end.
module gpps_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gpps_pkg::t_push       i_push,
    input  logic                  i_pop,
    output gpps_pkg::t_item       o_item,
    output gpps_pkg::t_q_status   o_status
);
    import gpps_pkg::*;

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_item           r_mem [Q_DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == CW'(Q_DEPTH));
    assign w_push = i_push.valid && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_item = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/gpps_back.sv
// Back end: path-start set-up (divide, sqrt, ln) and per-step log update and exp.
module gpps_back #(
    parameter int PRICE_FRAC_BITS  = gpps_pkg::DEF_PRICE_FRAC_BITS,
    parameter int SAMPLE_FRAC_BITS = gpps_pkg::DEF_SAMPLE_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gpps_pkg::t_cfg                     i_cfg,
    input  gpps_pkg::t_item                    i_item,
    input  logic                               i_item_valid,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [gpps_pkg::PRICE_W-1:0]       o_price,
    output logic [gpps_pkg::IDX_W-1:0]         o_step_index,
    output logic                               o_path_end
);
    import gpps_pkg::*;

    t_back_state r_state, n_state;
    t_item       r_item, n_item;

    logic [DT_W-1:0]          r_num, n_num;
    logic [STEPS_W-1:0]       r_rem, n_rem;
    logic [5:0]               r_cnt, n_cnt;
    logic signed [31:0]       r_m, n_m;
    logic [53:0]              r_pa, n_pa;
    logic [46:0]              r_pb, n_pb;
    logic signed [LOG_W-1:0]  r_drift, n_drift;
    logic [55:0]              r_x, n_x;
    logic [55:0]              r_r, n_r;
    logic [55:0]              r_bit, n_bit;
    logic [DIFF_W-1:0]        r_diff, n_diff;
    logic [PRICE_W-1:0]       r_norm, n_norm;
    logic [5:0]               r_p, n_p;
    logic [30:0]              r_lm, n_lm;
    logic [23:0]              r_frac, n_frac;
    logic signed [LOG_W-1:0]  r_log, n_log;
    logic signed [48:0]       r_dprod, n_dprod;
    logic signed [32:0]       r_t, n_t;
    logic signed [8:0]        r_n, n_n;
    logic [29:0]              r_z, n_z;
    logic [30:0]              r_term, n_term;
    logic [31:0]              r_sum, n_sum;
    logic [30:0]              r_v, n_v;
    logic [30:0]              r_qe, n_qe;
    logic [3:0]               r_k, n_k;
    logic [PRICE_W-1:0]       r_price, n_price;
    logic                     r_out_valid, n_out_valid;
    logic [PRICE_W-1:0]       r_out_price, n_out_price;
    logic [IDX_W-1:0]         r_out_idx, n_out_idx;
    logic                     r_out_last, n_out_last;

    logic [STEPS_W-1:0]       w_steps;
    logic [STEPS_W:0]         w_div_sh;
    logic [STEPS_W:0]         w_div_sub;
    logic                     w_div_ge;
    logic [37:0]              w_vsq;
    logic signed [29:0]       w_drift_sh;
    logic signed [31:0]       w_m_calc;
    logic [30:0]              w_mag;
    logic [38:0]              w_amag;
    logic [55:0]              w_sq_t;
    logic [46:0]              w_dp;
    logic [61:0]              w_lsq;
    logic [31:0]              w_lsh;
    logic signed [6:0]        w_pd;
    logic signed [30:0]       w_l2;
    logic signed [63:0]       w_lnp;
    logic signed [48:0]       w_dterm;
    logic signed [49:0]       w_lsum;
    logic signed [30:0]       w_yc;
    logic signed [62:0]       w_ty;
    logic [53:0]              w_zp;
    logic [60:0]              w_tz;
    logic [62:0]              w_vr;
    logic [34:0]              w_qk;
    logic [34:0]              w_rem;
    logic [30:0]              w_q;
    logic signed [9:0]        w_s;
    logic [9:0]               w_sr;
    logic [40:0]              w_shl;

    assign w_steps    = (i_cfg.step_count == '0) ? STEPS_W'(1) : i_cfg.step_count;
    assign w_div_sh   = {r_rem, r_num[DT_W-1]};
    assign w_div_ge   = w_div_sh >= {1'b0, w_steps};
    assign w_div_sub  = w_div_sh - {1'b0, w_steps};
    assign w_vsq      = i_cfg.volatility * i_cfg.volatility;
    assign w_drift_sh = {i_cfg.drift_rate, 8'b0};
    assign w_m_calc   = w_drift_sh - $signed({3'b0, w_vsq[37:9]});
    assign w_mag      = r_m[31] ? 31'(-r_m) : r_m[30:0];
    assign w_amag     = 39'((55'(r_pa) + 55'(r_pb[46:16])) >> 16);
    assign w_sq_t     = r_r + r_bit;
    assign w_dp       = i_cfg.volatility * r_r[27:0];
    assign w_lsq      = r_lm * r_lm;
    assign w_lsh      = w_lsq[61:30];
    assign w_pd       = $signed({1'b0, r_p}) - 7'(PRICE_FRAC_BITS);
    assign w_l2       = {w_pd, r_frac};
    assign w_lnp      = w_l2 * $signed({1'b0, LN2_Q32});
    assign w_dterm    = r_dprod >>> SAMPLE_FRAC_BITS;
    assign w_lsum     = 50'(r_log) + 50'(r_drift) + 50'(w_dterm);
    assign w_ty       = w_yc * $signed({1'b0, LOG2E_Q30});
    assign w_zp       = r_t[23:0] * LN2_Q30;
    assign w_tz       = r_term * r_z;
    assign w_vr       = r_v * f_recip(r_k);
    assign w_qk       = r_qe * r_k;
    assign w_rem      = 35'(r_v) - w_qk;
    assign w_q        = (w_rem >= 35'(r_k)) ? r_qe + 1'b1 : r_qe;
    assign w_s        = 10'(r_n) + 10'(PRICE_FRAC_BITS) - 10'sd30;
    assign w_sr       = 10'(-w_s);
    assign w_shl      = {9'b0, r_sum} << w_s[3:0];

    // clamp to +-32.0 before the log2(e) multiply
    always_comb begin
        if (r_log > EXP_LIM) begin
            w_yc = EXP_LIM[30:0];
        end else if (r_log < -EXP_LIM) begin
            w_yc = 31'(-EXP_LIM);
        end else begin
            w_yc = r_log[30:0];
        end
    end

    always_comb begin
        n_state = r_state;   n_item = r_item;    n_num = r_num;     n_rem = r_rem;
        n_cnt = r_cnt;       n_m = r_m;          n_pa = r_pa;       n_pb = r_pb;
        n_drift = r_drift;   n_x = r_x;          n_r = r_r;         n_bit = r_bit;
        n_diff = r_diff;     n_norm = r_norm;    n_p = r_p;         n_lm = r_lm;
        n_frac = r_frac;     n_log = r_log;      n_dprod = r_dprod; n_t = r_t;
        n_n = r_n;           n_z = r_z;          n_term = r_term;   n_sum = r_sum;
        n_v = r_v;           n_qe = r_qe;        n_k = r_k;         n_price = r_price;
        n_out_price = r_out_price;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_ready;
        o_pop = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    n_rem  = '0;
                    n_cnt  = '0;
                    n_num  = (i_cfg.end_time > i_cfg.start_time) ?
                             {i_cfg.end_time - i_cfg.start_time, 16'b0} : '0;
                    n_state = i_item.start ? S_DIV : S_STEP_MUL;
                end
            end
            // dt = ((end-start) << 16) / steps, one quotient bit a cycle
            S_DIV: begin
                n_rem = w_div_ge ? w_div_sub[STEPS_W-1:0] : w_div_sh[STEPS_W-1:0];
                n_num = {r_num[DT_W-2:0], w_div_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'(DT_W - 1)) begin
                    n_state = S_DRIFT_M;
                end
            end
            S_DRIFT_M: begin
                n_m = w_m_calc;
                n_state = S_DRIFT_A;
            end
            S_DRIFT_A: begin
                n_pa = w_mag * r_num[DT_W-1:16];
                n_pb = w_mag * r_num[15:0];
                n_state = S_DRIFT_SUM;
            end
            S_DRIFT_SUM: begin
                n_drift = r_m[31] ? -$signed({1'b0, w_amag}) : $signed({1'b0, w_amag});
                n_x   = {1'b0, r_num, 16'b0};
                n_r   = '0;
                n_bit = 56'(1) << 54;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_x >= w_sq_t) begin
                    n_x = r_x - w_sq_t;
                    n_r = (r_r >> 1) + r_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_diff = 32'(w_dp[46:16]);
                n_norm = (i_cfg.initial_price == '0) ? PRICE_W'(1) : i_cfg.initial_price;
                n_p    = 6'(PRICE_W - 1);
                n_state = S_LN_NORM;
            end
            // find the leading one a bit at a time
            S_LN_NORM: begin
                if (r_norm[PRICE_W-1]) begin
                    n_lm   = r_norm[PRICE_W-1:9];
                    n_frac = '0;
                    n_cnt  = '0;
                    n_state = S_LN_SQ;
                end else begin
                    n_norm = r_norm << 1;
                    n_p    = r_p - 1'b1;
                end
            end
            S_LN_SQ: begin
                if (w_lsh[31]) begin
                    n_lm   = w_lsh[31:1];
                    n_frac = {r_frac[22:0], 1'b1};
                end else begin
                    n_lm   = w_lsh[30:0];
                    n_frac = {r_frac[22:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd23) begin
                    n_state = S_LN_MUL;
                end
            end
            S_LN_MUL: begin
                n_log = LOG_W'(w_lnp >>> 32);
                n_state = S_STEP_MUL;
            end
            S_STEP_MUL: begin
                n_dprod = $signed({1'b0, r_diff}) * $signed(r_item.sample);
                n_state = S_STEP_SUM;
            end
            S_STEP_SUM: begin
                if (w_lsum[49:39] != {11{w_lsum[49]}}) begin
                    n_log = w_lsum[49] ? {1'b1, {(LOG_W-1){1'b0}}} : {1'b0, {(LOG_W-1){1'b1}}};
                end else begin
                    n_log = w_lsum[LOG_W-1:0];
                end
                n_state = S_EXP_MUL;
            end
            S_EXP_MUL: begin
                n_t = 33'(w_ty >>> 30);
                n_state = S_EXP_Z;
            end
            S_EXP_Z: begin
                n_n    = r_t[32:24];
                n_z    = w_zp[53:24];
                n_term = 31'(1) << 30;
                n_sum  = 32'(1) << 30;
                n_k    = 4'd1;
                n_state = S_TAY_A;
            end
            // Taylor term k: multiply by z, then divide by k via reciprocal and fix-up
            S_TAY_A: begin
                n_v = w_tz[60:30];
                n_state = S_TAY_B;
            end
            S_TAY_B: begin
                n_qe = w_vr[62:32];
                n_state = S_TAY_C;
            end
            S_TAY_C: begin
                n_term = w_q;
                n_sum  = r_sum + 32'(w_q);
                n_k    = r_k + 1'b1;
                n_state = (r_k == 4'(TAYLOR_TERMS)) ? S_EXP_SHIFT : S_TAY_A;
            end
            S_EXP_SHIFT: begin
                if (!w_s[9]) begin
                    if (w_s > 10'sd9 || w_shl[40]) begin
                        n_price = '1;
                    end else begin
                        n_price = w_shl[PRICE_W-1:0];
                    end
                end else if (w_sr >= 10'd63) begin
                    n_price = '0;
                end else begin
                    n_price = PRICE_W'(r_sum >> w_sr[5:0]);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_price = r_price;
                    n_out_idx   = r_item.idx;
                    n_out_last  = r_item.last;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;   r_num <= n_num;     r_rem <= n_rem;       r_cnt <= n_cnt;
        r_m <= n_m;         r_pa <= n_pa;       r_pb <= n_pb;         r_drift <= n_drift;
        r_x <= n_x;         r_r <= n_r;         r_bit <= n_bit;       r_diff <= n_diff;
        r_norm <= n_norm;   r_p <= n_p;         r_lm <= n_lm;         r_frac <= n_frac;
        r_log <= n_log;     r_dprod <= n_dprod; r_t <= n_t;           r_n <= n_n;
        r_z <= n_z;         r_term <= n_term;   r_sum <= n_sum;       r_v <= n_v;
        r_qe <= n_qe;       r_k <= n_k;         r_price <= n_price;
        r_out_price <= n_out_price;
        r_out_idx   <= n_out_idx;
        r_out_last  <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_price      = r_out_price;
    assign o_step_index = r_out_idx;
    assign o_path_end   = r_out_last;

endmodule

>>> rtl/gbm_price_path_step.sv
// Top level of the GBM price path step block: configuration registers and the front/back split.
//
// Each input word on i_valid/o_ready brings one standard-normal sample (Q4.12). Each word
// gives exactly one result word on o_valid/i_ready: the price after this step (Q24.16,
// saturating), its step index within the path and a path-end flag on the last step.
// Configuration goes through i_cfg_valid/o_cfg_ready with a register index and data;
// o_cfg_ready is always high. Write it only while the block holds no work.
// The front end tags words with step index and path start/end and places them in a
// two-word queue; it keeps taking words while the back end is busy until the queue fills.
// The back end runs one word at a time through a multi-cycle sequencer. An ordinary step
// runs the 13-term exp series, each term a multiply by z, a reciprocal multiply and a
// fix-up. The first step of a path adds the set-up: a bit-serial divide for dt, a square
// root, a leading-one search and 24 squaring steps for the log.
// The result waits in an output register; while the receiver stalls the back end still
// finishes the next word and then holds it. Synchronous reset returns the registers to
// their defaults, empties the queue and starts a new path.
module gbm_price_path_step #(
    parameter int PRICE_FRAC_BITS  = gpps_pkg::DEF_PRICE_FRAC_BITS,
    parameter int SAMPLE_FRAC_BITS = gpps_pkg::DEF_SAMPLE_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [gpps_pkg::SAMPLE_W-1:0]   i_normal_sample,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [gpps_pkg::PRICE_W-1:0]           o_price,
    output logic [gpps_pkg::IDX_W-1:0]             o_step_index,
    output logic                                   o_path_end,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [gpps_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [gpps_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import gpps_pkg::*;

    t_cfg      r_cfg;
    t_push     w_push;
    t_item     w_head;
    t_q_status w_q_status;
    logic      w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drift_rate    <= '0;
            r_cfg.volatility    <= '0;
            r_cfg.initial_price <= PRICE_W'(1) << PRICE_FRAC_BITS;
            r_cfg.start_time    <= '0;
            r_cfg.end_time      <= '0;
            r_cfg.step_count    <= STEPS_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DRIFT_RATE:    r_cfg.drift_rate    <= i_cfg_data[DRIFT_W-1:0];
                CFG_VOLATILITY:    r_cfg.volatility    <= i_cfg_data[VOL_W-1:0];
                CFG_INITIAL_PRICE: r_cfg.initial_price <= i_cfg_data[PRICE_W-1:0];
                CFG_START_TIME:    r_cfg.start_time    <= i_cfg_data[TIME_W-1:0];
                CFG_END_TIME:      r_cfg.end_time      <= i_cfg_data[TIME_W-1:0];
                CFG_STEP_COUNT:    r_cfg.step_count    <= i_cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    gpps_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_normal_sample (i_normal_sample),
        .i_step_count    (r_cfg.step_count),
        .i_q_status      (w_q_status),
        .o_push          (w_push)
    );

    gpps_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_item   (w_head),
        .o_status (w_q_status)
    );

    gpps_back #(
        .PRICE_FRAC_BITS  (PRICE_FRAC_BITS),
        .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (w_head),
        .i_item_valid (!w_q_status.empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_price      (o_price),
        .o_step_index (o_step_index),
        .o_path_end   (o_path_end)
    );

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("back end popped an empty queue");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !w_q_status.empty)
        else $error("accepted word missing from queue");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result word presented straight after reset");

endmodule
